// ===== hdl/dcfc_pkg.sv =====
// Shared types, constants and helper functions of the dusk candle flicker controller.
package dcfc_pkg;

  // Request kinds.
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_NIGHT_LEVEL   = 2'd0;
  localparam logic [1:0] REG_DAY_LEVEL     = 2'd1;
  localparam logic [1:0] REG_TRIGGER_COUNT = 2'd2;
  localparam logic [1:0] REG_BURN_MINUTES  = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [7:0] NIGHT_LEVEL_RST   = 8'd30;
  localparam logic [7:0] DAY_LEVEL_RST     = 8'd4;
  localparam logic [7:0] TRIGGER_COUNT_RST = 8'd5;
  localparam logic [7:0] BURN_MINUTES_RST  = 8'd180;

  // Random generator and duty constants.
  localparam logic [15:0] LCG_ADD      = 16'd13849;
  localparam logic [15:0] LCG_SEED     = 16'h3333;
  localparam logic [6:0]  DUTY_MID     = 7'd50;
  localparam logic [6:0]  DUTY_MIN     = 7'd22;
  localparam logic [6:0]  DUTY_MAX     = 7'd78;
  localparam logic [2:0]  STRENGTH_RST = 3'd4;
  localparam logic [2:0]  AMP_TOP      = 3'd7;

  // Mode codes as they appear on the result channel.
  localparam logic [1:0] MODE_CODE_NIGHT  = 2'd0;
  localparam logic [1:0] MODE_CODE_DAY    = 2'd1;
  localparam logic [1:0] MODE_CODE_CANDLE = 2'd2;

  // Operating mode, one-hot.
  typedef enum logic [2:0] {
    MODE_NIGHT  = 3'b001,
    MODE_DAY    = 3'b010,
    MODE_CANDLE = 3'b100
  } mode_t;

  typedef struct packed {
    logic [7:0] night_level;
    logic [7:0] day_level;
    logic [7:0] trigger_count;
    logic [7:0] burn_minutes;
  } dcfc_cfg_t;

  typedef struct packed {
    logic [1:0] mode_now;
    logic       pwm_on;
    logic [6:0] duty;
    logic       stepped;
  } dcfc_res_t;

  // Flicker state going into one flicker step.
  typedef struct packed {
    logic [15:0] lfsr;
    logic [7:0]  step_count;
    logic [7:0]  minutes_left;
    logic [2:0]  strength;
    logic        sign_neg;
  } dcfc_flk_in_t;

  // Flicker state after one flicker step.
  typedef struct packed {
    logic [15:0] lfsr;
    logic [7:0]  step_count;
    logic [7:0]  minutes_left;
    logic [2:0]  strength;
    logic        sign_neg;
    logic [6:0]  duty;
    logic [7:0]  hold_ticks;
    logic        burn_done;
  } dcfc_flk_out_t;

  // Map a mode to its result code.
  function automatic logic [1:0] mode_code(input mode_t m);
    logic [1:0] c;
    case (m)
      MODE_NIGHT:  c = MODE_CODE_NIGHT;
      MODE_DAY:    c = MODE_CODE_DAY;
      MODE_CANDLE: c = MODE_CODE_CANDLE;
      default:     c = MODE_CODE_DAY;
    endcase
    return c;
  endfunction

  // Next generator value: x * 2053 + 13849, with 2053 = 2048 + 4 + 1.
  function automatic logic [15:0] lcg_next(input logic [15:0] x);
    return (x << 11) + (x << 2) + x + LCG_ADD;
  endfunction

  // Flicker amplitude strength * k by shift and add; at most 4 * 7.
  function automatic logic [4:0] amp_of(input logic [2:0] s, input logic [2:0] k);
    logic [4:0] a;
    a = 5'd0;
    if (k[0]) a = a + {2'b00, s};
    if (k[1]) a = a + {1'b0, s, 1'b0};
    if (k[2]) a = a + {s, 2'b00};
    return a;
  endfunction

  // Hold time for a random value r: (r * r >> 1) + r + 2.
  function automatic logic [7:0] hold_of(input logic [2:0] r);
    logic [7:0] h;
    case (r)
      3'd0:    h = 8'd2;
      3'd1:    h = 8'd3;
      3'd2:    h = 8'd6;
      3'd3:    h = 8'd9;
      3'd4:    h = 8'd14;
      3'd5:    h = 8'd19;
      3'd6:    h = 8'd26;
      3'd7:    h = 8'd33;
      default: h = 8'd2;
    endcase
    return h;
  endfunction

endpackage

// ===== hdl/dcfc_ifs.sv =====
// Request and result channel interfaces of the dusk candle flicker controller.
interface dcfc_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] darkness;

  modport source (output valid, output req_type, output darkness, input ready);
  modport sink (input valid, input req_type, input darkness, output ready);
endinterface

interface dcfc_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode_now;
  logic       pwm_on;
  logic [6:0] duty;
  logic       stepped;

  modport source (output valid, output mode_now, output pwm_on, output duty,
                  output stepped, input ready);
  modport sink (input valid, input mode_now, input pwm_on, input duty,
                input stepped, output ready);
endinterface

// ===== hdl/dcfc_flicker.sv =====
// One flicker step: generator advance, minute count, duty and hold time.
module dcfc_flicker import dcfc_pkg::*; (
  input  dcfc_flk_in_t  flk_in,
  output dcfc_flk_out_t flk_out
);

  logic [15:0] lfsr_new;
  logic [7:0]  step_new;
  logic        wrap;
  logic [2:0]  strength_new;
  logic [2:0]  r;
  logic [4:0]  amp;
  logic        sign_new;

  // Advance the generator and the step counter.
  assign lfsr_new = lcg_next(flk_in.lfsr);
  assign step_new = flk_in.step_count + 8'd1;
  assign wrap     = (step_new == 8'd0);

  // A new minute picks a new strength from 1 to 4.
  assign strength_new = wrap ? ({1'b0, lfsr_new[15:14]} + 3'd1) : flk_in.strength;

  // Duty swings around the midpoint with alternating sign.
  assign r        = lfsr_new[15:13];
  assign sign_new = ~flk_in.sign_neg;
  assign amp      = amp_of(strength_new, AMP_TOP - r);

  always_comb begin
    flk_out.lfsr         = lfsr_new;
    flk_out.step_count   = step_new;
    flk_out.minutes_left = wrap ? (flk_in.minutes_left - 8'd1) : flk_in.minutes_left;
    flk_out.strength     = strength_new;
    flk_out.sign_neg     = sign_new;
    flk_out.duty         = sign_new ? (DUTY_MID - {2'b00, amp}) : (DUTY_MID + {2'b00, amp});
    flk_out.hold_ticks   = hold_of(r);
    flk_out.burn_done    = (flk_out.minutes_left == 8'd0);
  end

endmodule

// ===== hdl/dcfc_core.sv =====
// Controller state registers and the per-request next-state logic.
module dcfc_core import dcfc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic       req_type,
  input  logic [7:0] darkness,
  input  dcfc_cfg_t  cfg,
  output dcfc_res_t  res_next
);

  mode_t       mode, mode_next;
  logic [7:0]  agree_count, agree_count_next;
  logic [15:0] lfsr_value, lfsr_value_next;
  logic [7:0]  minutes_left, minutes_left_next;
  logic [2:0]  strength, strength_next;
  logic        sign_neg, sign_neg_next;
  logic [7:0]  step_count, step_count_next;
  logic [7:0]  hold_ticks, hold_ticks_next;
  logic [6:0]  duty_reg, duty_reg_next;

  logic          is_tick;
  logic          agree;
  logic [7:0]    count_upd;
  logic          trig_hit;
  logic          enter_candle;
  logic [7:0]    hold_dec;
  logic          do_step;
  dcfc_flk_in_t  flk_in;
  dcfc_flk_out_t flk_out;

  // Light sample evaluation against the awaited condition.
  assign is_tick   = (req_type == REQ_TICK);
  assign agree     = (mode == MODE_DAY) ? (darkness > cfg.night_level)
                                        : (darkness <= cfg.day_level);
  assign count_upd = agree ? (agree_count + 8'd1)
                           : ((agree_count != 8'd0) ? (agree_count - 8'd1) : 8'd0);
  assign trig_hit  = (count_upd >= cfg.trigger_count);
  assign enter_candle = (mode == MODE_DAY) && !is_tick && trig_hit;
  assign hold_dec  = (hold_ticks != 8'd0) ? (hold_ticks - 8'd1) : 8'd0;

  // A step on entry starts from a fresh burn.
  always_comb begin
    if (enter_candle) begin
      flk_in.lfsr         = lfsr_value;
      flk_in.step_count   = 8'd0;
      flk_in.minutes_left = cfg.burn_minutes;
      flk_in.strength     = STRENGTH_RST;
      flk_in.sign_neg     = 1'b0;
    end else begin
      flk_in.lfsr         = lfsr_value;
      flk_in.step_count   = step_count;
      flk_in.minutes_left = minutes_left;
      flk_in.strength     = strength;
      flk_in.sign_neg     = sign_neg;
    end
  end

  dcfc_flicker u_flicker (
    .flk_in  (flk_in),
    .flk_out (flk_out)
  );

  // Next state for the request in the input register.
  always_comb begin
    mode_next         = mode;
    agree_count_next  = agree_count;
    lfsr_value_next   = lfsr_value;
    minutes_left_next = minutes_left;
    strength_next     = strength;
    sign_neg_next     = sign_neg;
    step_count_next   = step_count;
    hold_ticks_next   = hold_ticks;
    duty_reg_next     = duty_reg;
    do_step           = 1'b0;
    case (mode)
      MODE_CANDLE: begin
        if (is_tick) begin
          hold_ticks_next = hold_dec;
          do_step         = (hold_dec == 8'd0);
        end
      end
      MODE_NIGHT, MODE_DAY: begin
        if (!is_tick) begin
          agree_count_next = count_upd;
          if (trig_hit) begin
            agree_count_next = 8'd0;
            if (mode == MODE_NIGHT) begin
              mode_next = MODE_DAY;
            end else begin
              mode_next         = MODE_CANDLE;
              minutes_left_next = cfg.burn_minutes;
              strength_next     = STRENGTH_RST;
              sign_neg_next     = 1'b0;
              step_count_next   = 8'd0;
              if (cfg.burn_minutes == 8'd0) begin
                mode_next = MODE_NIGHT;
              end else begin
                do_step = (hold_ticks == 8'd0);
              end
            end
          end
        end
      end
      default: begin
        mode_next = mode;
      end
    endcase
    // Apply a flicker step; the last step of a burn drops back to night.
    if (do_step) begin
      lfsr_value_next   = flk_out.lfsr;
      step_count_next   = flk_out.step_count;
      minutes_left_next = flk_out.minutes_left;
      strength_next     = flk_out.strength;
      sign_neg_next     = flk_out.sign_neg;
      duty_reg_next     = flk_out.duty;
      hold_ticks_next   = flk_out.hold_ticks;
      if (flk_out.burn_done) begin
        mode_next        = MODE_NIGHT;
        agree_count_next = 8'd0;
      end
    end
  end

  // Result of the request, taken from the state after it.
  always_comb begin
    res_next.mode_now = mode_code(mode_next);
    res_next.pwm_on   = (mode_next == MODE_CANDLE);
    res_next.duty     = duty_reg_next;
    res_next.stepped  = do_step;
  end

  // State registers advance once per request.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_DAY;
      agree_count  <= 8'd0;
      lfsr_value   <= LCG_SEED;
      minutes_left <= 8'd0;
      strength     <= STRENGTH_RST;
      sign_neg     <= 1'b0;
      step_count   <= 8'd0;
      hold_ticks   <= 8'd0;
      duty_reg     <= 7'd0;
    end else if (fire) begin
      mode         <= mode_next;
      agree_count  <= agree_count_next;
      lfsr_value   <= lfsr_value_next;
      minutes_left <= minutes_left_next;
      strength     <= strength_next;
      sign_neg     <= sign_neg_next;
      step_count   <= step_count_next;
      hold_ticks   <= hold_ticks_next;
      duty_reg     <= duty_reg_next;
    end
  end

endmodule

// ===== hdl/dusk_candle_flicker_controller_top.sv =====
// Top level of the dusk candle flicker controller.
//
//   channel | direction | fields
//   --------+-----------+---------------------------------------
//   req     | in        | req_type, darkness
//   res     | out       | mode_now, pwm_on, duty, stepped
//   wr_*    | in        | wr_index, wr_data (write only)
//
// A request waits in the input register; its result is loaded into the result register when
// the result side is free to advance, and the result register then offers it on res.
// The state loop closes through the core state registers alone, so one request is accepted
// per cycle when the result side keeps up.
// Reset is synchronous and returns the configuration registers, valid flags and core state to their defaults.
// A stalled result holds the result register; the input register still takes a request
// when it is empty, then the request side stalls until the result moves on.
module dusk_candle_flicker_controller_top import dcfc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  dcfc_req_if.sink   req,
  dcfc_res_if.source res,
  input  logic       wr_en,
  input  logic [1:0] wr_index,
  input  logic [7:0] wr_data
);

  dcfc_cfg_t  cfg;
  logic       in_valid;
  logic       in_req_type;
  logic [7:0] in_darkness;
  logic       out_valid;
  dcfc_res_t  out_res;
  dcfc_res_t  res_next;
  logic       advance;
  logic       fire;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.night_level   <= NIGHT_LEVEL_RST;
      cfg.day_level     <= DAY_LEVEL_RST;
      cfg.trigger_count <= TRIGGER_COUNT_RST;
      cfg.burn_minutes  <= BURN_MINUTES_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_NIGHT_LEVEL:   cfg.night_level   <= wr_data;
        REG_DAY_LEVEL:     cfg.day_level     <= wr_data;
        REG_TRIGGER_COUNT: cfg.trigger_count <= wr_data;
        REG_BURN_MINUTES:  cfg.burn_minutes  <= wr_data;
        default:           cfg.burn_minutes  <= cfg.burn_minutes;
      endcase
    end
  end

  // Flow control between input register and result register.
  assign advance   = !out_valid || res.ready;
  assign fire      = in_valid && advance;
  assign req.ready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_req_type <= req.req_type;
      in_darkness <= req.darkness;
    end
  end

  dcfc_core u_core (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .req_type (in_req_type),
    .darkness (in_darkness),
    .cfg      (cfg),
    .res_next (res_next)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= res_next;
    end
  end

  assign res.valid    = out_valid;
  assign res.mode_now = out_res.mode_now;
  assign res.pwm_on   = out_res.pwm_on;
  assign res.duty     = out_res.duty;
  assign res.stepped  = out_res.stepped;

  // The PWM runs exactly while the candle burns.
  a_pwm_mode: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.pwm_on == (res.mode_now == MODE_CODE_CANDLE)))
    else $error("pwm_on disagrees with mode_now");

  // A flicker step always lands in the 22 to 78 duty window.
  a_step_duty: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.stepped |-> (res.duty >= DUTY_MIN) && (res.duty <= DUTY_MAX))
    else $error("flicker duty out of range");

  // A step leaves the block burning or back in night mode, never in day mode.
  a_step_mode: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.stepped |-> (res.mode_now != MODE_CODE_DAY))
    else $error("flicker step reported in day mode");

endmodule

// ===== dv/dusk_candle_flicker_controller_top_tb.sv =====
// Self-checking testbench for the dusk candle flicker controller top level.
`timescale 1ns / 1ps

module dusk_candle_flicker_controller_top_tb import dcfc_pkg::*; ();

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int LCG_MUL     = 2053;

  // Request as queued for the driver.
  typedef struct packed {
    logic       kind;
    logic [7:0] darkness;
  } light_req_t;

  // Ways the result side can hold off.
  typedef enum logic [1:0] {
    READY_STEADY,
    READY_RANDOM,
    READY_PATTERN
  } ready_style_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       wr_en;
  logic [1:0] wr_index;
  logic [7:0] wr_data;

  dcfc_req_if req_ch ();
  dcfc_res_if res_ch ();

  dusk_candle_flicker_controller_top u_top (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch),
    .res      (res_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  // Candle state as the checker expects it.
  dcfc_cfg_t   cfg;
  logic [1:0]  cand_mode;
  logic [7:0]  agree_run;
  logic [15:0] lcg_state;
  logic [7:0]  minutes_remaining;
  logic [2:0]  flicker_gain;
  logic        neg_swing;
  logic [7:0]  step_index;
  logic [7:0]  hold_left;
  logic [6:0]  duty_level;

  light_req_t   pending_reqs[$];
  dcfc_res_t    expected_results[$];
  int unsigned  queued_count;
  int unsigned  accepted_count;
  int unsigned  fail_count;
  int unsigned  cycle_count;
  logic         req_taken;
  int unsigned  burst_left;
  int unsigned  gap_left;
  ready_style_t ready_style;
  int unsigned  ready_span;
  logic [15:0]  ready_pattern;

  // Clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // One flicker step: advance the generator, then derive duty and hold time.
  task automatic step_flicker();
    int r;
    int amp;
    lcg_state = 16'(lcg_state * LCG_MUL + LCG_ADD);
    step_index = step_index + 8'd1;
    if (step_index == 8'd0) begin
      minutes_remaining = minutes_remaining - 8'd1;
      flicker_gain = 3'(1 + lcg_state[15:14]);
    end
    r = int'(lcg_state[15:13]);
    neg_swing = ~neg_swing;
    amp = flicker_gain * (AMP_TOP - r);
    duty_level = neg_swing ? 7'(DUTY_MID - amp) : 7'(DUTY_MID + amp);
    hold_left = 8'(((r * r) >> 1) + r + 2);
    if (minutes_remaining == 8'd0) begin
      cand_mode = MODE_CODE_NIGHT;
      agree_run = 8'd0;
    end
  endtask

  // Apply one accepted request to the expected state and queue its result.
  task automatic predict_candle_result(input logic kind, input logic [7:0] dark);
    dcfc_res_t want;
    logic      stepped;
    logic      agree;
    stepped = 1'b0;
    if (cand_mode == MODE_CODE_CANDLE) begin
      if (kind == REQ_TICK) begin
        if (hold_left != 8'd0) hold_left = hold_left - 8'd1;
        if (hold_left == 8'd0) begin
          step_flicker();
          stepped = 1'b1;
        end
      end
    end else if (kind == REQ_SAMPLE) begin
      agree = (cand_mode == MODE_CODE_DAY) ? (dark > cfg.night_level)
                                           : (dark <= cfg.day_level);
      if (agree) agree_run = agree_run + 8'd1;
      else if (agree_run != 8'd0) agree_run = agree_run - 8'd1;
      if (agree_run >= cfg.trigger_count) begin
        agree_run = 8'd0;
        if (cand_mode == MODE_CODE_NIGHT) begin
          cand_mode = MODE_CODE_DAY;
        end else begin
          // Light the candle; a hold left from the last burn still runs out first.
          cand_mode = MODE_CODE_CANDLE;
          minutes_remaining = cfg.burn_minutes;
          flicker_gain = STRENGTH_RST;
          neg_swing = 1'b0;
          step_index = 8'd0;
          if (minutes_remaining == 8'd0) begin
            cand_mode = MODE_CODE_NIGHT;
          end else if (hold_left == 8'd0) begin
            step_flicker();
            stepped = 1'b1;
          end
        end
      end
    end
    want.mode_now = cand_mode;
    want.pwm_on   = (cand_mode == MODE_CODE_CANDLE);
    want.duty     = duty_level;
    want.stepped  = stepped;
    expected_results.push_back(want);
  endtask

  task automatic flag_mismatch(input string field, input logic [7:0] want_v,
                               input logic [7:0] got_v);
    fail_count++;
    $error("%s mismatch: expected %0d, got %0d", field, want_v, got_v);
  endtask

  // Register writes, request acceptance and result checking.
  always @(posedge clk) begin : check_results
    dcfc_res_t want;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_NIGHT_LEVEL:   cfg.night_level = wr_data;
          REG_DAY_LEVEL:     cfg.day_level = wr_data;
          REG_TRIGGER_COUNT: cfg.trigger_count = wr_data;
          REG_BURN_MINUTES:  cfg.burn_minutes = wr_data;
          default: ;
        endcase
      end
      if (res_ch.valid && res_ch.ready) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          $error("result arrived with no request outstanding");
        end else begin
          want = expected_results.pop_front();
          if (res_ch.mode_now !== want.mode_now)
            flag_mismatch("mode_now", 8'(want.mode_now), 8'(res_ch.mode_now));
          if (res_ch.pwm_on !== want.pwm_on)
            flag_mismatch("pwm_on", 8'(want.pwm_on), 8'(res_ch.pwm_on));
          if (res_ch.duty !== want.duty)
            flag_mismatch("duty", 8'(want.duty), 8'(res_ch.duty));
          if (res_ch.stepped !== want.stepped)
            flag_mismatch("stepped", 8'(want.stepped), 8'(res_ch.stepped));
        end
      end
      req_taken <= req_ch.valid && req_ch.ready;
      if (req_ch.valid && req_ch.ready) begin
        accepted_count++;
        predict_candle_result(req_ch.req_type, req_ch.darkness);
      end
    end
  end

  // Request driver: bursts of random length with random gaps between them.
  always @(negedge clk) begin : drive_requests
    light_req_t next_req;
    logic       next_valid;
    next_req.kind     = req_ch.req_type;
    next_req.darkness = req_ch.darkness;
    next_valid        = req_ch.valid;
    if (rst) begin
      next_valid = 1'b0;
    end else if (!req_ch.valid || req_taken) begin
      next_valid = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
      end else if (pending_reqs.size() != 0) begin
        next_req   = pending_reqs.pop_front();
        next_valid = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(24, 1);
          gap_left   = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
        end
      end
    end
    req_ch.valid    <= next_valid;
    req_ch.req_type <= next_req.kind;
    req_ch.darkness <= next_req.darkness;
  end

  // Result side: steady, random or patterned stalls, with the style picked anew when its random span runs out.
  always @(negedge clk) begin : drive_ready
    logic next_ready;
    if (ready_span == 0) begin
      ready_style   = ready_style_t'($urandom_range(2, 0));
      ready_span    = $urandom_range(80, 20);
      ready_pattern = 16'($urandom);
    end else begin
      ready_span--;
    end
    case (ready_style)
      READY_STEADY: next_ready = 1'b1;
      READY_RANDOM: next_ready = ($urandom_range(3, 0) != 0);
      default: begin
        next_ready    = ready_pattern[0];
        ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
      end
    endcase
    res_ch.ready <= next_ready;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("dusk_candle_flicker_controller_top_tb NOT OK");
      $finish;
    end
  end

  // Queue one request, keeping the queue short so biasing tracks the mode.
  task automatic push_request(input logic kind, input logic [7:0] dark);
    while (pending_reqs.size() > 1) @(posedge clk);
    pending_reqs.push_back('{kind, dark});
    queued_count++;
  endtask

  // Wait until every queued request has been taken and answered.
  task automatic wait_idle();
    @(negedge clk);
    while (accepted_count != queued_count || expected_results.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= value;
    @(negedge clk);
    wr_en    <= 1'b0;
  endtask

  task automatic configure(input logic [7:0] night, input logic [7:0] day,
                           input logic [7:0] trig, input logic [7:0] burn);
    wait_idle();
    write_reg(REG_NIGHT_LEVEL, night);
    write_reg(REG_DAY_LEVEL, day);
    write_reg(REG_TRIGGER_COUNT, trig);
    write_reg(REG_BURN_MINUTES, burn);
  endtask

  // Darkness that agrees (or not) with what the current wait mode is looking for.
  function automatic logic [7:0] darkness_for(input logic agree);
    if (cand_mode == MODE_CODE_DAY) begin
      if (agree && cfg.night_level != 8'hFF)
        return 8'($urandom_range(255, cfg.night_level + 1));
      if (!agree) return 8'($urandom_range(cfg.night_level, 0));
    end else if (cand_mode == MODE_CODE_NIGHT) begin
      if (agree) return 8'($urandom_range(cfg.day_level, 0));
      if (cfg.day_level != 8'hFF) return 8'($urandom_range(255, cfg.day_level + 1));
    end
    return 8'($urandom_range(255, 0));
  endfunction

  // Mostly well-formed sample runs, with ticks and fully random samples mixed in.
  task automatic run_mixed(input int count, input int tick_pct, input int agree_pct);
    int roll;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99, 0);
      if (roll < tick_pct)
        push_request(REQ_TICK, 8'($urandom));
      else if (roll >= 90)
        push_request(REQ_SAMPLE, 8'($urandom));
      else
        push_request(REQ_SAMPLE, darkness_for($urandom_range(99, 0) < agree_pct));
    end
  endtask

  initial begin : stimulus
    int tries;
    cfg               = '{NIGHT_LEVEL_RST, DAY_LEVEL_RST, TRIGGER_COUNT_RST, BURN_MINUTES_RST};
    cand_mode         = MODE_CODE_DAY;
    agree_run         = 8'd0;
    lcg_state         = LCG_SEED;
    minutes_remaining = 8'd0;
    flicker_gain      = STRENGTH_RST;
    neg_swing         = 1'b0;
    step_index        = 8'd0;
    hold_left         = 8'd0;
    duty_level        = 7'd0;
    queued_count      = 0;
    accepted_count    = 0;
    fail_count        = 0;
    cycle_count       = 0;
    burst_left        = 0;
    gap_left          = 0;
    ready_span        = 0;
    ready_style       = READY_STEADY;
    ready_pattern     = 16'hFFFF;
    req_taken         = 1'b0;
    req_ch.valid      = 1'b0;
    req_ch.req_type   = REQ_SAMPLE;
    req_ch.darkness   = 8'd0;
    res_ch.ready      = 1'b0;
    wr_en             = 1'b0;
    wr_index          = REG_NIGHT_LEVEL;
    wr_data           = 8'd0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset thresholds: a tick in day mode is ignored, the count floors at zero,
    // a level equal to the threshold does not count, and four nets stay short of five.
    push_request(REQ_TICK, 8'd255);
    push_request(REQ_SAMPLE, 8'd0);
    push_request(REQ_SAMPLE, 8'd30);
    push_request(REQ_SAMPLE, 8'd31);
    push_request(REQ_SAMPLE, 8'd255);
    push_request(REQ_SAMPLE, 8'd0);
    push_request(REQ_SAMPLE, 8'd128);
    push_request(REQ_SAMPLE, 8'd200);
    push_request(REQ_SAMPLE, 8'd77);

    // Shortest burn: the fifth agreeing sample lights the candle and steps at once.
    configure(NIGHT_LEVEL_RST, DAY_LEVEL_RST, TRIGGER_COUNT_RST, 8'd1);
    push_request(REQ_SAMPLE, 8'd255);
    // Samples while burning are ignored.
    push_request(REQ_SAMPLE, 8'd0);
    push_request(REQ_SAMPLE, 8'd255);
    for (int i = 0; i < 13; i++) push_request(REQ_TICK, (i % 2 == 0) ? 8'd0 : 8'd255);

    // Let the one-minute burn run out, which wraps the step count and ends in night.
    while (cand_mode == MODE_CODE_CANDLE) begin
      if ($urandom_range(19, 0) == 0) push_request(REQ_SAMPLE, 8'($urandom));
      else push_request(REQ_TICK, 8'($urandom));
    end

    // Extreme levels with the longest trigger; the zero burn goes straight back to night.
    configure(8'd0, 8'd255, 8'd255, 8'd0);
    run_mixed(560, 5, 95);

    // Zero trigger: any sample advances the mode, even one that disagrees.
    configure(8'd255, 8'd0, 8'd0, 8'd0);
    run_mixed(100, 20, 50);

    configure(NIGHT_LEVEL_RST, DAY_LEVEL_RST, TRIGGER_COUNT_RST, 8'd0);
    run_mixed(250, 15, 75);

    for (int p = 0; p < 3; p++) begin
      configure(8'($urandom_range(254, 0)), 8'($urandom_range(254, 0)),
                8'($urandom_range(12, 1)), 8'd0);
      run_mixed(200, 15, 75);
    end

    // Longest burn; the hold left from the first burn is counted down before any step.
    configure(8'($urandom_range(200, 0)), 8'($urandom_range(254, 0)), 8'd3, 8'd255);
    tries = 0;
    while (cand_mode != MODE_CODE_CANDLE && tries < 500) begin
      push_request(REQ_SAMPLE, darkness_for(1'b1));
      tries++;
    end
    run_mixed(250, 85, 75);

    wait_idle();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("dusk_candle_flicker_controller_top_tb OK");
    end else begin
      $display("dusk_candle_flicker_controller_top_tb NOT OK");
    end
    $finish;
  end

endmodule
